### design/sca_pkg.sv
// sca_pkg: shared types and constants of the sound channel allocator
// depends on nothing; imported by sca_fifo, sound_channel_allocator and the test bench
`default_nettype none

package sca_pkg;

	// input action codes
	localparam logic [1:0] ACT_QUEUE = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// result kind codes
	localparam logic [1:0] KIND_PLAY = 2'd0;
	localparam logic [1:0] KIND_HALT = 2'd1;
	localparam logic [1:0] KIND_DROP = 2'd2;

	// most play results one tick may produce
	localparam logic [4:0] MAX_RES = 5'd16;

	// quarter second at 44.1 kHz, added to every hold time
	localparam logic [24:0] HOLD_EXTRA = 25'd11025;

	// width of the register write data and of its saturation compare
	localparam int CFG_W = 5;
	localparam int CMP_W = 7;

	// one queued request
	typedef struct packed {
		logic [15:0] handle;
		logic [7:0]  volume;
		logic [8:0]  loops;
		logic [24:0] hold;
	} req_t;

	// queue control from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
	} fifo_ctl_t;

	// queue status to the sequencer
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

### design/sca_fifo.sv
// sca_fifo: request queue, a memory with head pointer and fill count
// depends on sca_pkg; head entry is read into a register every cycle
`default_nettype none

module sca_fifo
	import sca_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire fifo_ctl_t  ctl,
	input  wire req_t       wr_data,
	output req_t            rd_data,
	output fifo_stat_t      stat
);

	localparam int QI_W = $clog2(QUEUE_DEPTH);
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	req_t            mem [QUEUE_DEPTH];
	req_t            rd_q;
	logic [QI_W-1:0] head_q;
	logic [QC_W-1:0] count_q;
	logic [QC_W:0]   tail_sum;
	logic [QI_W-1:0] tail;

	// tail = (head + count) mod depth, sum stays below twice the depth
	always_comb begin
		tail_sum = (QC_W + 1)'(head_q) + (QC_W + 1)'(count_q);
		if (tail_sum >= (QC_W + 1)'(QUEUE_DEPTH))
			tail = QI_W'(tail_sum - (QC_W + 1)'(QUEUE_DEPTH));
		else
			tail = QI_W'(tail_sum);
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.flush) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
			if (head_q == QI_W'(QUEUE_DEPTH - 1))
				head_q <= '0;
			else
				head_q <= head_q + 1'b1;
		end
	end

	// storage, registered read of the head entry
	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[tail] <= wr_data;
		rd_q <= mem[head_q];
	end

	assign rd_data    = rd_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QC_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

### design/sound_channel_allocator.sv
// sound_channel_allocator: top level, built on sca_pkg and sca_fifo; one request at a time
// A queued request is stored at its accept edge; a drop or halt-all result is held at
// acceptance and moves to the output register once the output is free. A tick sweeps one
// channel timer per cycle through a shared subtractor, then scans channels, stepping past
// busy ones one per cycle; each dispatch passes through the fetch state and waits while a
// held result cannot leave. The next request is taken once the last result is registered.
// Reset empties the queue, frees every channel and sets the limit to min(NUM_CHANNELS, 16).
`default_nettype none

module sound_channel_allocator
	import sca_pkg::*;
#(
	parameter int NUM_CHANNELS = 16,
	parameter int QUEUE_DEPTH  = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// input requests
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        action,
	input  wire logic [15:0]       sound_handle,
	input  wire logic [25:0]       sample_bytes,
	input  wire logic [7:0]        volume,
	input  wire logic signed [8:0] loops,
	input  wire logic [19:0]       elapsed_samples,
	// results
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             kind,
	output logic [3:0]             channel_number,
	output logic [15:0]            sound_handle_out,
	output logic [7:0]             volume_out,
	output logic signed [8:0]      loops_out,
	output logic                   last
);

	localparam int LIM_W       = $clog2(NUM_CHANNELS + 1);
	localparam int CH_IW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RESET_LIMIT = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_FETCH,
		S_SCAN,
		S_FLUSH
	} state_t;

	state_t            state_q;
	logic [LIM_W-1:0]  limit_q;
	logic [NUM_CHANNELS-1:0] busy_q;
	logic [19:0]       elapsed_q;
	logic [LIM_W-1:0]  sw_idx_q;
	logic              sw_vld_s1;
	logic [CH_IW-1:0]  sw_idx_s1;
	logic [LIM_W-1:0]  ch_q;
	logic [4:0]        n_q;

	// result waiting for the output register
	logic              hold_vld_q;
	logic [1:0]        hold_kind_q;
	logic [3:0]        hold_ch_q;
	logic [15:0]       hold_handle_q;
	logic [7:0]        hold_vol_q;
	logic [8:0]        hold_loops_q;

	// output register
	logic              out_vld_q;
	logic [1:0]        out_kind_q;
	logic [3:0]        out_ch_q;
	logic [15:0]       out_handle_q;
	logic [7:0]        out_vol_q;
	logic [8:0]        out_loops_q;
	logic              out_last_q;

	// timer memory
	logic [24:0]       tmem [NUM_CHANNELS];
	logic [24:0]       tmr_rd_q;
	logic              tm_we;
	logic [CH_IW-1:0]  tm_waddr;
	logic [24:0]       tm_wdata;

	fifo_ctl_t         fctl;
	fifo_stat_t        fstat;
	req_t              push_req;
	req_t              head_req;

	logic              in_acc;
	logic              out_free;
	logic              out_load;
	logic              scan_done;
	logic              dispatch_go;
	logic [CH_IW-1:0]  ch_idx;
	logic              sw_rd_en;
	logic [25:0]       diff;
	logic              expire;
	logic [CMP_W-1:0]  cfg_ext;
	logic [CMP_W-1:0]  cfg_sat;

	sca_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl),
		.wr_data (push_req),
		.rd_data (head_req),
		.stat    (fstat)
	);

	// handshake terms
	assign in_acc    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_vld_q || !out_stall;
	assign cfg_ready = 1'b1;

	// register value saturates at the channel count
	assign cfg_ext = CMP_W'(cfg_data);
	assign cfg_sat = (cfg_ext > CMP_W'(NUM_CHANNELS)) ? CMP_W'(NUM_CHANNELS) : cfg_ext;

	// new queue entry, hold time is sound length plus a quarter second
	always_comb begin
		push_req.handle = sound_handle;
		push_req.volume = volume;
		push_req.loops  = loops;
		push_req.hold   = 25'(sample_bytes[25:2]) + HOLD_EXTRA;
	end

	// shared subtractor for the timer sweep
	assign diff   = {1'b0, tmr_rd_q} - {6'b0, elapsed_q};
	assign expire = diff[25] || (diff == '0);

	// dispatch scan
	assign ch_idx      = ch_q[CH_IW-1:0];
	assign scan_done   = fstat.empty || (n_q == MAX_RES) || (ch_q >= limit_q);
	assign dispatch_go = (state_q == S_SCAN) && !scan_done && !busy_q[ch_idx]
		&& (!hold_vld_q || out_free);

	// output register takes the waiting result
	assign out_load = (dispatch_go && hold_vld_q) || ((state_q == S_FLUSH) && out_free);

	// queue control
	always_comb begin
		fctl.push  = in_acc && (action == ACT_QUEUE) && !fstat.full;
		fctl.pop   = dispatch_go;
		fctl.flush = in_acc && (action == ACT_CLEAR);
	end

	// timer write: countdown during the sweep, hold time at dispatch
	always_comb begin
		sw_rd_en = (state_q == S_SWEEP) && (sw_idx_q < LIM_W'(NUM_CHANNELS));
		if (dispatch_go) begin
			tm_we    = 1'b1;
			tm_waddr = ch_idx;
			tm_wdata = head_req.hold;
		end else begin
			tm_we    = sw_vld_s1 && busy_q[sw_idx_s1] && !expire;
			tm_waddr = sw_idx_s1;
			tm_wdata = diff[24:0];
		end
	end

	// timer storage, registered read
	always_ff @(posedge clk) begin
		if (tm_we)
			tmem[tm_waddr] <= tm_wdata;
		if (sw_rd_en)
			tmr_rd_q <= tmem[sw_idx_q[CH_IW-1:0]];
	end

	// sequencer, channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_q    <= LIM_W'(RESET_LIMIT);
			busy_q     <= '0;
			sw_vld_s1  <= 1'b0;
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_q <= LIM_W'(cfg_sat);

			if (out_vld_q && !out_stall && !out_load)
				out_vld_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (action)
							ACT_QUEUE: begin
								if (fstat.full) begin
									hold_vld_q    <= 1'b1;
									hold_kind_q   <= KIND_DROP;
									hold_ch_q     <= '0;
									hold_handle_q <= sound_handle;
									hold_vol_q    <= volume;
									hold_loops_q  <= loops;
									state_q       <= S_FLUSH;
								end
							end
							ACT_TICK: begin
								elapsed_q <= elapsed_samples;
								sw_idx_q  <= '0;
								sw_vld_s1 <= 1'b0;
								state_q   <= S_SWEEP;
							end
							ACT_CLEAR: begin
								busy_q        <= '0;
								hold_vld_q    <= 1'b1;
								hold_kind_q   <= KIND_HALT;
								hold_ch_q     <= '0;
								hold_handle_q <= '0;
								hold_vol_q    <= '0;
								hold_loops_q  <= '0;
								state_q       <= S_FLUSH;
							end
							default: begin
							end
						endcase
					end
				end

				S_SWEEP: begin
					// stage 0 reads a timer, stage 1 counts it down
					sw_vld_s1 <= sw_rd_en;
					sw_idx_s1 <= sw_idx_q[CH_IW-1:0];
					if (sw_rd_en)
						sw_idx_q <= sw_idx_q + 1'b1;
					if (sw_vld_s1 && busy_q[sw_idx_s1] && expire)
						busy_q[sw_idx_s1] <= 1'b0;
					if (!sw_rd_en && !sw_vld_s1) begin
						ch_q    <= '0;
						n_q     <= '0;
						state_q <= S_FETCH;
					end
				end

				S_FETCH: begin
					// head entry read settles
					state_q <= S_SCAN;
				end

				S_SCAN: begin
					if (scan_done) begin
						state_q <= hold_vld_q ? S_FLUSH : S_IDLE;
					end else if (busy_q[ch_idx]) begin
						ch_q <= ch_q + 1'b1;
					end else if (dispatch_go) begin
						// previous play result is not the last one
						if (hold_vld_q) begin
							out_vld_q    <= 1'b1;
							out_kind_q   <= hold_kind_q;
							out_ch_q     <= hold_ch_q;
							out_handle_q <= hold_handle_q;
							out_vol_q    <= hold_vol_q;
							out_loops_q  <= hold_loops_q;
							out_last_q   <= 1'b0;
						end
						hold_vld_q     <= 1'b1;
						hold_kind_q    <= KIND_PLAY;
						hold_ch_q      <= 4'(ch_idx);
						hold_handle_q  <= head_req.handle;
						hold_vol_q     <= head_req.volume;
						hold_loops_q   <= head_req.loops;
						busy_q[ch_idx] <= 1'b1;
						ch_q           <= ch_q + 1'b1;
						n_q            <= n_q + 1'b1;
						state_q        <= S_FETCH;
					end
				end

				S_FLUSH: begin
					if (out_free) begin
						out_vld_q    <= 1'b1;
						out_kind_q   <= hold_kind_q;
						out_ch_q     <= hold_ch_q;
						out_handle_q <= hold_handle_q;
						out_vol_q    <= hold_vol_q;
						out_loops_q  <= hold_loops_q;
						out_last_q   <= 1'b1;
						hold_vld_q   <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign out_valid        = out_vld_q;
	assign kind             = out_kind_q;
	assign channel_number   = out_ch_q;
	assign sound_handle_out = out_handle_q;
	assign volume_out       = out_vol_q;
	assign loops_out        = out_loops_q;
	assign last             = out_last_q;

endmodule

`default_nettype wire

### sim/sound_channel_allocator_test.sv
// sound_channel_allocator_test: self-checking bench for the playback voice allocator
// drives a directed table and random requests, predicts every result in-line
// depends on design/sca_pkg.sv and design/sound_channel_allocator.sv
`default_nettype none

module sound_channel_allocator_test;
	import sca_pkg::*;

	localparam int NCH = 16;
	localparam int QDEPTH = 16;
	localparam int DISPATCH_CAP = 16;
	localparam logic [24:0] HOLD_PAD = 25'd11025;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 100;
	localparam int PRESSURE_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 21;
	localparam int NUM_PHASES = 6;

	// how a request's results are known
	typedef enum {BY_MODEL, NO_RESULT, HALT_RESULT, DROP_RESULT} check_mode_t;

	typedef struct {
		logic [1:0]        act;
		logic [15:0]       handle;
		logic [25:0]       bytes;
		logic [7:0]        vol;
		logic signed [8:0] loops;
		logic [19:0]       elapsed;
		check_mode_t       mode;
	} sound_req_t;

	typedef struct {
		logic [1:0]        kind;
		logic [3:0]        chan;
		logic [15:0]       handle;
		logic [7:0]        vol;
		logic signed [8:0] loops;
		logic              last;
	} voice_result_t;

	// dut ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [4:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        action = '0;
	logic [15:0]       sound_handle = '0;
	logic [25:0]       sample_bytes = '0;
	logic [7:0]        volume = '0;
	logic signed [8:0] loops = '0;
	logic [19:0]       elapsed_samples = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        kind;
	logic [3:0]        channel_number;
	logic [15:0]       sound_handle_out;
	logic [7:0]        volume_out;
	logic signed [8:0] loops_out;
	logic              last;

	// allocator state as predicted
	req_t          queued[QDEPTH];
	logic [3:0]    q_head;
	logic [4:0]    q_count;
	logic [15:0]   chan_busy;
	logic [24:0]   chan_timer[NCH];
	int            chan_limit;

	voice_result_t model_out[$];
	voice_result_t voice_results_due[$];
	sound_req_t    directed_reqs[$];
	int            mismatches = 0;
	logic          no_idle = 1'b0;
	logic          pressure_req = 1'b0;
	logic          pressure_done = 1'b0;

	sound_channel_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.sound_handle(sound_handle), .sample_bytes(sample_bytes), .volume(volume),
		.loops(loops), .elapsed_samples(elapsed_samples),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.channel_number(channel_number), .sound_handle_out(sound_handle_out),
		.volume_out(volume_out), .loops_out(loops_out), .last(last)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic voice_result_t make_result(input logic [1:0] k, input logic [3:0] ch,
			input logic [15:0] h, input logic [7:0] v, input logic signed [8:0] l,
			input logic lst);
		voice_result_t res;
		res.kind = k;
		res.chan = ch;
		res.handle = h;
		res.vol = v;
		res.loops = l;
		res.last = lst;
		return res;
	endfunction

	// advance the predicted allocator by one request, results go to model_out
	function automatic void advance_allocator(input sound_req_t r);
		int i;
		int ch;
		int n;
		logic stuck;
		logic [3:0] slot;
		voice_result_t v;
		model_out.delete();
		case (r.act)
			ACT_QUEUE: begin
				if (q_count >= QDEPTH) begin
					model_out.insert(model_out.size(), make_result(KIND_DROP, 4'd0,
						r.handle, r.vol, r.loops, 1'b1));
				end else begin
					slot = 4'(q_head + q_count);
					queued[slot].handle = r.handle;
					queued[slot].volume = r.vol;
					queued[slot].loops = r.loops;
					queued[slot].hold = {1'b0, r.bytes[25:2]} + HOLD_PAD;
					q_count = q_count + 5'd1;
				end
			end
			ACT_TICK: begin
				// count down busy channels
				for (i = 0; i < NCH; i++) begin
					if (chan_busy[i]) begin
						if (chan_timer[i] <= {5'd0, r.elapsed}) begin
							chan_timer[i] = '0;
							chan_busy[i] = 1'b0;
						end else begin
							chan_timer[i] = chan_timer[i] - {5'd0, r.elapsed};
						end
					end
				end
				// dispatch in queue order to the lowest free channel
				n = 0;
				stuck = 1'b0;
				while (q_count != 0 && n < DISPATCH_CAP && !stuck) begin
					ch = -1;
					for (i = 0; i < chan_limit && i < NCH; i++)
						if (ch < 0 && !chan_busy[i])
							ch = i;
					if (ch < 0) begin
						stuck = 1'b1;
					end else begin
						chan_busy[ch] = 1'b1;
						chan_timer[ch] = queued[q_head].hold;
						model_out.insert(model_out.size(), make_result(KIND_PLAY, 4'(ch),
							queued[q_head].handle, queued[q_head].volume,
							queued[q_head].loops, 1'b0));
						n++;
						q_head = q_head + 4'd1;
						q_count = q_count - 5'd1;
					end
				end
				if (n > 0) begin
					v = model_out.pop_back();
					v.last = 1'b1;
					model_out.insert(model_out.size(), v);
				end
			end
			ACT_CLEAR: begin
				q_head = '0;
				q_count = '0;
				chan_busy = '0;
				for (i = 0; i < NCH; i++)
					chan_timer[i] = '0;
				model_out.insert(model_out.size(), make_result(KIND_HALT, 4'd0, 16'd0,
					8'd0, 9'sd0, 1'b1));
			end
			default: ;
		endcase
	endfunction

	function automatic int idle_gap();
		int sel;
		if (no_idle)
			return 0;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_row(input logic [1:0] a, input logic [15:0] h,
			input logic [25:0] b, input logic [7:0] v, input logic signed [8:0] l,
			input logic [19:0] e, input check_mode_t m);
		sound_req_t r;
		r.act = a;
		r.handle = h;
		r.bytes = b;
		r.vol = v;
		r.loops = l;
		r.elapsed = e;
		r.mode = m;
		directed_reqs.insert(directed_reqs.size(), r);
	endfunction

	function automatic sound_req_t random_request();
		sound_req_t r;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 48)
			r.act = ACT_QUEUE;
		else if (sel < 88)
			r.act = ACT_TICK;
		else if (sel < 94)
			r.act = ACT_CLEAR;
		else
			r.act = ACT_UNUSED;
		r.handle = 16'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 70)
			r.bytes = 26'($urandom_range(0, 120000));
		else if (sel < 85)
			r.bytes = 26'($urandom);
		else
			r.bytes = 26'($urandom_range(0, 64));
		r.vol = 8'($urandom_range(0, 128));
		r.loops = 9'(int'($urandom_range(0, 256)) - 1);
		sel = $urandom_range(0, 99);
		if (sel < 40)
			r.elapsed = 20'($urandom_range(0, 15000));
		else if (sel < 60)
			r.elapsed = 20'($urandom_range(15000, 60000));
		else if (sel < 70)
			r.elapsed = 20'd0;
		else if (sel < 80)
			r.elapsed = 20'hFFFFF;
		else
			r.elapsed = 20'($urandom);
		r.mode = BY_MODEL;
		return r;
	endfunction

	// offer one request, hold it until accepted, then predict
	task automatic drive_request(input sound_req_t r);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		sound_handle <= r.handle;
		sample_bytes <= r.bytes;
		volume <= r.vol;
		loops <= r.loops;
		elapsed_samples <= r.elapsed;
		do @(posedge clk); while (in_stall);
		advance_allocator(r);
		case (r.mode)
			BY_MODEL: foreach (model_out[i])
				voice_results_due.insert(voice_results_due.size(), model_out[i]);
			HALT_RESULT: voice_results_due.insert(voice_results_due.size(),
				make_result(KIND_HALT, 4'd0, 16'd0, 8'd0, 9'sd0, 1'b1));
			DROP_RESULT: voice_results_due.insert(voice_results_due.size(),
				make_result(KIND_DROP, 4'd0, r.handle, r.vol, r.loops, 1'b1));
			default: ;
		endcase
	endtask

	// all results in, then let a silent dispatch sweep finish
	task automatic wait_until_drained();
		while (voice_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_channel_limit(input logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		chan_limit = (v > NCH) ? NCH : int'(v);
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		voice_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (voice_results_due.size() == 0) begin
				$error("unexpected result: kind %0d channel %0d", kind, channel_number);
				mismatches++;
			end else begin
				e = voice_results_due.pop_front();
				check_field("kind", e.kind, kind);
				check_field("channel_number", e.chan, channel_number);
				check_field("sound_handle_out", e.handle, sound_handle_out);
				check_field("volume_out", e.vol, volume_out);
				check_field("loops_out", int'(e.loops), int'(loops_out));
				check_field("last", e.last, last);
			end
		end
	end

	// result side stalls, with one long hold-off on request
	initial begin : result_sink
		int n;
		@(posedge arst_n);
		forever begin
			if (pressure_req && !pressure_done) begin
				out_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end else begin
				n = idle_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int p;
		int k;
		int i;
		sound_req_t r;
		logic [4:0] plan[NUM_PHASES];
		logic [4:0] setting;

		plan[0] = 5'd1;
		plan[1] = 5'd0;
		plan[2] = 5'd31;
		plan[3] = 5'd4;
		plan[4] = 5'd16;
		plan[5] = 5'd0;

		// predicted reset state
		q_head = '0;
		q_count = '0;
		chan_busy = '0;
		for (i = 0; i < NCH; i++)
			chan_timer[i] = '0;
		chan_limit = 16;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, run at the reset channel count
		add_row(ACT_TICK, 16'd0, 26'd0, 8'd0, 9'sd0, 20'd0, NO_RESULT);
		add_row(ACT_UNUSED, 16'hFFFF, 26'h3FFFFFF, 8'hFF, -9'sd1, 20'hFFFFF, NO_RESULT);
		add_row(ACT_CLEAR, 16'hFFFF, 26'h3FFFFFF, 8'd128, -9'sd1, 20'hFFFFF, HALT_RESULT);
		// longest hold, shortest hold, one past the shortest
		add_row(ACT_QUEUE, 16'hFFFF, 26'h3FFFFFF, 8'd128, -9'sd1, 20'd0, BY_MODEL);
		add_row(ACT_QUEUE, 16'h0000, 26'd0, 8'd0, 9'sd0, 20'hFFFFF, BY_MODEL);
		add_row(ACT_QUEUE, 16'h5A5A, 26'd4, 8'd127, 9'sd255, 20'd0, BY_MODEL);
		// plays on channels 0..2 in order
		add_row(ACT_TICK, 16'd0, 26'd0, 8'd0, 9'sd0, 20'd0, BY_MODEL);
		// timer hits exactly zero on channel 1
		add_row(ACT_TICK, 16'd0, 26'd0, 8'd0, 9'sd0, 20'd11025, BY_MODEL);
		add_row(ACT_TICK, 16'd0, 26'd0, 8'd0, 9'sd0, 20'hFFFFF, BY_MODEL);
		// channel 0 still busy, next play skips it
		add_row(ACT_QUEUE, 16'hA5A5, 26'h2AAAAAA, 8'h55, 9'sh0AA, 20'h55555, BY_MODEL);
		add_row(ACT_TICK, 16'd0, 26'd0, 8'd0, 9'sd0, 20'h55555, BY_MODEL);
		add_row(ACT_CLEAR, 16'd0, 26'd0, 8'd0, 9'sd0, 20'd0, HALT_RESULT);
		// fill the queue, overflow it, then a full sixteen-play tick
		for (k = 0; k < QDEPTH; k++)
			add_row(ACT_QUEUE, 16'(k * 16'h1111), 26'(k * 4096), 8'(k * 8), 9'(k - 1),
				20'(k), BY_MODEL);
		add_row(ACT_QUEUE, 16'hBEEF, 26'h1555555, 8'd128, -9'sd1, 20'hAAAAA, DROP_RESULT);
		add_row(ACT_TICK, 16'd0, 26'd0, 8'd0, 9'sd0, 20'd0, BY_MODEL);

		foreach (directed_reqs[j])
			drive_request(directed_reqs[j]);
		in_valid <= 1'b0;

		// random phases, each at its own channel count
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_until_drained();
			setting = (p == NUM_PHASES - 1) ? 5'($urandom_range(1, 31)) : plan[p];
			write_channel_limit(setting);
			no_idle = (p == 4);
			if (p == 2)
				pressure_req = 1'b1;
			k = 0;
			while (k < ITEMS_PER_PHASE) begin
				r = random_request();
				drive_request(r);
				if (r.act != ACT_UNUSED)
					k++;
			end
			in_valid <= 1'b0;
		end

		wait_until_drained();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
design/sca_pkg.sv
design/sca_fifo.sv
design/sound_channel_allocator.sv
sim/sound_channel_allocator_test.sv
